@@ src/ibbc_pkg.sv @@
package ibbc_pkg;

  localparam int STORE_DEPTH_DEF = 4096;

  localparam int CMD_W      = 3;
  localparam int POS_W      = 12;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 13;
  localparam int EPOCH_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_START      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_VTX = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND_RST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE_VTX  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE_RST  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FINISH     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VTX_LIMIT = 2'd1;

  localparam logic [CNT_W-1:0] CAP_RESET    = 13'd4096;
  localparam logic [VAL_W-1:0] RESTART_MARK = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] SHORT_LIMIT  = 32'h0000_FFFF;
  // Largest range (highest minus lowest) that still fits the 16-bit format.
  localparam logic [VAL_W-1:0] SHORT_SPAN   = 32'h0000_FFFE;

  typedef struct packed {
    logic               use_short;
    logic [VAL_W-1:0]   base;
    logic [CNT_W-1:0]   fill;
    logic [VAL_W-1:0]   lo;
    logic [VAL_W-1:0]   hi;
    logic [EPOCH_W-1:0] epoch;
  } build_t;

  typedef struct packed {
    logic valid;
    logic is_read;
    logic status;
  } issue_t;

endpackage

@@ src/ibbc_ram.sv @@
module ibbc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ibbc_cmd.sv @@
module ibbc_cmd
  import ibbc_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [CMD_W-1:0]               in_cmd,
  input  logic [POS_W-1:0]               in_slot_position,
  input  logic [VAL_W-1:0]               in_vertex_value,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           issue_free,
  output issue_t                         issue,
  output build_t                         build,
  output logic                           ram_we,
  output logic [$clog2(STORE_DEPTH)-1:0] ram_waddr,
  output logic [EPOCH_W+VAL_W-1:0]       ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(STORE_DEPTH)-1:0] ram_raddr
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CMP_W = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  typedef enum logic {ST_CLEAR, ST_RUN} state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]   capacity_r;
  logic [VAL_W-1:0]   vlimit_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [VAL_W-1:0]   lo_r, lo_nxt;
  logic [VAL_W-1:0]   hi_r, hi_nxt;
  logic               short_r, short_nxt;
  logic [VAL_W-1:0]   base_r, base_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;

  logic [CMP_W-1:0]   depth_c, cap_ext, lim, fill_ext, pos_ext;
  logic [VAL_W-1:0]   span;
  logic               fire, vtx_cmd, vtx_bad;
  logic               status, is_read, wr_req, rd_req;
  logic [AW-1:0]      wr_addr;
  logic [VAL_W-1:0]   wr_val;

  assign depth_c  = CMP_W'(STORE_DEPTH);
  assign cap_ext  = CMP_W'(capacity_r);
  assign lim      = (cap_ext < depth_c) ? cap_ext : depth_c;
  assign fill_ext = CMP_W'(fill_r);
  assign pos_ext  = CMP_W'(in_slot_position);
  assign span     = (lo_r < hi_r) ? (hi_r - lo_r) : '0;

  assign in_ready  = (state_r == ST_RUN) && issue_free;
  assign fire      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign vtx_cmd = (in_cmd == CMD_APPEND_VTX) || (in_cmd == CMD_WRITE_VTX);
  assign vtx_bad = vtx_cmd && (in_vertex_value > vlimit_r);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    fill_nxt     = fill_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    short_nxt    = short_r;
    base_nxt     = base_r;
    epoch_nxt    = epoch_r;
    status       = 1'b0;
    is_read      = 1'b0;
    wr_req       = 1'b0;
    rd_req       = 1'b0;
    wr_addr      = pos_ext[AW-1:0];
    wr_val       = vtx_cmd ? in_vertex_value : RESTART_MARK;

    case (in_cmd)
      CMD_START: begin
        fill_nxt  = '0;
        lo_nxt    = '1;
        hi_nxt    = '0;
        short_nxt = 1'b0;
        base_nxt  = '0;
        // Stale entries are hidden by the epoch tag; once the tag space runs
        // out, the store is swept back to zero instead.
        if (epoch_r == {EPOCH_W{1'b1}}) begin
          epoch_nxt    = '0;
          state_nxt    = ST_CLEAR;
          clr_addr_nxt = '0;
        end else begin
          epoch_nxt = epoch_r + EPOCH_W'(1);
        end
      end
      CMD_APPEND_VTX, CMD_APPEND_RST: begin
        if (fill_ext >= lim || vtx_bad) begin
          status = 1'b1;
        end else begin
          wr_req   = 1'b1;
          wr_addr  = fill_ext[AW-1:0];
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      CMD_WRITE_VTX, CMD_WRITE_RST: begin
        if (pos_ext >= lim || vtx_bad) begin
          status = 1'b1;
        end else begin
          wr_req = 1'b1;
          if (pos_ext >= fill_ext) begin
            fill_nxt = CNT_W'(pos_ext + CMP_W'(1));
          end
        end
      end
      CMD_FINISH: begin
        if (span <= SHORT_SPAN) begin
          short_nxt = 1'b1;
          base_nxt  = (hi_r >= SHORT_LIMIT) ? lo_r : '0;
        end else begin
          short_nxt = 1'b0;
          base_nxt  = '0;
        end
      end
      CMD_READ: begin
        if (pos_ext >= fill_ext || pos_ext >= depth_c) begin
          status = 1'b1;
        end else begin
          rd_req  = 1'b1;
          is_read = 1'b1;
        end
      end
      default: begin
        status = 1'b1;
      end
    endcase

    if (wr_req && vtx_cmd) begin
      lo_nxt = (in_vertex_value < lo_r) ? in_vertex_value : lo_r;
      hi_nxt = (in_vertex_value > hi_r) ? in_vertex_value : hi_r;
    end

    if (state_r == ST_CLEAR) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(STORE_DEPTH - 1)) begin
        state_nxt = ST_RUN;
      end
    end
  end

  assign ram_we    = (state_r == ST_CLEAR) || (fire && wr_req);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr;
  assign ram_wdata = (state_r == ST_CLEAR) ? '0 : {epoch_r, wr_val};
  assign ram_re    = fire && rd_req;
  assign ram_raddr = pos_ext[AW-1:0];

  assign issue.valid   = fire;
  assign issue.is_read = is_read;
  assign issue.status  = status;

  assign build.use_short = short_r;
  assign build.base      = base_r;
  assign build.fill      = fill_r;
  assign build.lo        = lo_r;
  assign build.hi        = hi_r;
  assign build.epoch     = epoch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      capacity_r <= CAP_RESET;
      vlimit_r   <= '1;
      fill_r     <= '0;
      lo_r       <= '1;
      hi_r       <= '0;
      short_r    <= 1'b0;
      base_r     <= '0;
      epoch_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CAPACITY) begin
          capacity_r <= cfg_data[CNT_W-1:0];
        end else if (cfg_index == CFG_VTX_LIMIT) begin
          vlimit_r <= cfg_data[VAL_W-1:0];
        end
      end
      if (state_r == ST_CLEAR) begin
        state_r    <= state_nxt;
        clr_addr_r <= clr_addr_nxt;
      end else if (fire) begin
        state_r    <= state_nxt;
        clr_addr_r <= clr_addr_nxt;
        fill_r     <= fill_nxt;
        lo_r       <= lo_nxt;
        hi_r       <= hi_nxt;
        short_r    <= short_nxt;
        base_r     <= base_nxt;
        epoch_r    <= epoch_nxt;
      end
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during store clearing");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_cmd == CMD_START) |=> (fill_r == '0 && lo_r == '1 && hi_r == '0))
    else $error("start did not clear the build state");

  a_single_port_use: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re) && !(ram_re && state_r == ST_CLEAR))
    else $error("store written and read in the same cycle");

endmodule

@@ src/ibbc_out.sv @@
module ibbc_out
  import ibbc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  issue_t                   issue,
  input  build_t                   build,
  output logic                     issue_free,
  input  logic [EPOCH_W+VAL_W-1:0] ram_rdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic [VAL_W-1:0]         out_read_value,
  output logic                     out_short_format,
  output logic [VAL_W-1:0]         out_index_base,
  output logic [CNT_W-1:0]         out_fill_length,
  output logic [VAL_W-1:0]         out_lowest_seen,
  output logic [VAL_W-1:0]         out_highest_seen
);

  logic             s1_valid_r, s1_read_r, s1_status_r;
  logic             out_valid_r;
  logic             s1_go;
  logic [VAL_W-1:0] entry, diff, conv;

  assign s1_go      = s1_valid_r && (!out_valid_r || out_ready);
  assign issue_free = !s1_valid_r || s1_go;

  // An entry whose tag is from an earlier build reads as a cleared slot.
  assign entry = (ram_rdata[EPOCH_W+VAL_W-1:VAL_W] == build.epoch) ?
                 ram_rdata[VAL_W-1:0] : '0;
  assign diff  = entry - build.base;

  always_comb begin
    if (!build.use_short) begin
      conv = entry;
    end else if (build.base != '0) begin
      conv = (diff < SHORT_LIMIT) ? diff : SHORT_LIMIT;
    end else begin
      conv = entry & SHORT_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue_free) begin
        s1_valid_r <= issue.valid;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_free && issue.valid) begin
      s1_read_r   <= issue.is_read;
      s1_status_r <= issue.status;
    end
    if (s1_go) begin
      out_status       <= s1_status_r;
      out_read_value   <= s1_read_r ? conv : '0;
      out_short_format <= build.use_short;
      out_index_base   <= build.base;
      out_fill_length  <= build.fill;
      out_lowest_seen  <= build.lo;
      out_highest_seen <= build.hi;
    end
  end

  assign out_valid = out_valid_r;

  a_no_issue_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !issue.valid)
    else $error("new item taken while both stages are held");

endmodule

@@ src/index_buffer_builder_compactor.sv @@
// An accepted beat's store read and flags are registered in stage one, and its
// result in the output registers. Throughput: one item per cycle while results
// are taken; the store's single registered read port sets the two-stage pipe,
// and a held result backs up into input ready. Reset: synchronous, active low.
// After reset and every 256th start the store is swept to zero, in_ready low.
module index_buffer_builder_compactor
  import ibbc_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [POS_W-1:0]      in_slot_position,
  input  logic [VAL_W-1:0]      in_vertex_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_status,
  output logic [VAL_W-1:0]      out_read_value,
  output logic                  out_short_format,
  output logic [VAL_W-1:0]      out_index_base,
  output logic [CNT_W-1:0]      out_fill_length,
  output logic [VAL_W-1:0]      out_lowest_seen,
  output logic [VAL_W-1:0]      out_highest_seen,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  issue_t                   issue;
  build_t                   build;
  logic                     issue_free;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [EPOCH_W+VAL_W-1:0] ram_wdata, ram_rdata;

  ibbc_cmd #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_cmd (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_slot_position(in_slot_position),
    .in_vertex_value (in_vertex_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .issue_free      (issue_free),
    .issue           (issue),
    .build           (build),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr)
  );

  ibbc_ram #(
    .WIDTH(EPOCH_W + VAL_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ibbc_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .issue           (issue),
    .build           (build),
    .issue_free      (issue_free),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_short_format(out_short_format),
    .out_index_base  (out_index_base),
    .out_fill_length (out_fill_length),
    .out_lowest_seen (out_lowest_seen),
    .out_highest_seen(out_highest_seen)
  );

endmodule
